// ===== hw/rtl/utf8v_pkg.sv =====
// Shared types and constants for the UTF-8 text validator.
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

    // Width of the configuration limit registers.
    localparam int unsigned LIMIT_W = 13;
    localparam int unsigned CP_W    = 21;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_MAX_GLYPHS = 1'b0,
        CFG_MAX_LINES  = 1'b1
    } t_cfg_index;

    localparam logic [LIMIT_W-1:0] MAX_GLYPHS_RST = 13'd1800;
    localparam logic [LIMIT_W-1:0] MAX_LINES_RST  = 13'd96;

    // Error codes, first fault in stream order.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_LEAD  = 3'd1,
        ERR_BAD_CONT  = 3'd2,
        ERR_TRUNCATED = 3'd3,
        ERR_RANGE     = 3'd4,
        ERR_CONTROL   = 3'd5,
        ERR_LINES     = 3'd6,
        ERR_GLYPHS    = 3'd7
    } t_err;

    // Lead byte ranges.
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;

    // Code point limits.
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MIN_LEN2  = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_LEN3  = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_LEN4  = 21'h010000;
    localparam logic [CP_W-1:0] CP_CTRL_C0   = 21'h000020;
    localparam logic [CP_W-1:0] CP_DEL       = 21'h00007F;
    localparam logic [CP_W-1:0] CP_C1_HI     = 21'h00009F;
    localparam logic [CP_W-1:0] CP_TAB       = 21'h000009;
    localparam logic [CP_W-1:0] CP_LF        = 21'h00000A;
    localparam logic [CP_W-1:0] CP_CR        = 21'h00000D;

    // Sequence lengths.
    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [1:0]      bytes_left;
        logic [2:0]      seq_len;
        logic [CP_W-1:0] partial;
        t_err            first_error;
    } t_dec_state;

    localparam t_dec_state DEC_CLEAR = '{
        bytes_left:  2'd0,
        seq_len:     3'd0,
        partial:     '0,
        first_error: ERR_NONE
    };

    // Per-byte status produced by the decode step.
    typedef struct packed {
        logic            text_done;
        logic            text_ok;
        t_err            error_code;
        logic            glyph_done;
        logic [CP_W-1:0] code_point;
    } t_step_res;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8v_if.sv =====
// Handshake interfaces for the byte input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface utf8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_result_if #(
    parameter int unsigned COUNT_WIDTH = 14
);
    logic                   valid;
    logic                   ready;
    logic                   text_done;
    logic                   text_ok;
    logic [2:0]             error_code;
    logic                   glyph_done;
    logic [20:0]            code_point;
    logic [COUNT_WIDTH-1:0] glyph_count;
    logic [COUNT_WIDTH-1:0] line_count;

    modport source (
        output valid, output text_done, output text_ok, output error_code,
        output glyph_done, output code_point, output glyph_count, output line_count,
        input  ready
    );
    modport sink (
        input  valid, input text_done, input text_ok, input error_code,
        input  glyph_done, input code_point, input glyph_count, input line_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/utf8v_step.sv =====
// Single-byte UTF-8 decode, character checks and count/limit update.
`timescale 1ns / 1ps
`default_nettype none

module utf8v_step #(
    parameter int unsigned COUNT_WIDTH = 14
) (
    input  wire utf8v_pkg::t_dec_state            i_dec,
    input  wire logic [COUNT_WIDTH-1:0]           i_glyphs,
    input  wire logic [COUNT_WIDTH-1:0]           i_lines,
    input  wire logic [7:0]                       i_data_byte,
    input  wire logic                             i_last_byte,
    input  wire logic [utf8v_pkg::LIMIT_W-1:0]    i_max_glyphs,
    input  wire logic [utf8v_pkg::LIMIT_W-1:0]    i_max_lines,
    output utf8v_pkg::t_dec_state                 o_dec_next,
    output logic [COUNT_WIDTH-1:0]                o_glyphs_next,
    output logic [COUNT_WIDTH-1:0]                o_lines_next,
    output logic [COUNT_WIDTH-1:0]                o_glyph_count,
    output logic [COUNT_WIDTH-1:0]                o_line_count,
    output utf8v_pkg::t_step_res                  o_res
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > utf8v_pkg::LIMIT_W) ?
                                    COUNT_WIDTH : utf8v_pkg::LIMIT_W;

    logic [COUNT_WIDTH-1:0]      glyphs_bump;
    logic [COUNT_WIDTH-1:0]      lines_bump;
    logic                        glyphs_over;
    logic                        lines_over;
    utf8v_pkg::t_dec_state       dec;
    logic [COUNT_WIDTH-1:0]      glyphs;
    logic [COUNT_WIDTH-1:0]      lines;
    utf8v_pkg::t_err             err;
    logic                        complete;
    logic                        glyph;
    logic [utf8v_pkg::CP_W-1:0]  cp;
    logic [utf8v_pkg::CP_W-1:0]  cp_out;
    logic                        bad_range;
    logic                        bad_ctrl;

    // Saturating increments and limit compares.
    assign glyphs_bump = (i_glyphs == '1) ? i_glyphs : i_glyphs + 1'b1;
    assign lines_bump  = (i_lines == '1) ? i_lines : i_lines + 1'b1;
    assign glyphs_over = CMP_W'(glyphs_bump) > CMP_W'(i_max_glyphs);
    assign lines_over  = CMP_W'(lines_bump) > CMP_W'(i_max_lines);

    // Decode one byte.
    always_comb begin
        dec       = i_dec;
        glyphs    = i_glyphs;
        lines     = i_lines;
        err       = utf8v_pkg::ERR_NONE;
        complete  = 1'b0;
        glyph     = 1'b0;
        cp_out    = '0;
        cp        = '0;
        bad_range = 1'b0;
        bad_ctrl  = 1'b0;
        if (i_dec.first_error == utf8v_pkg::ERR_NONE) begin
            if (i_dec.bytes_left == 2'd0) begin
                if (!i_data_byte[7]) begin
                    dec.partial = {13'd0, i_data_byte};
                    dec.seq_len = utf8v_pkg::LEN_1;
                    complete    = 1'b1;
                end else if (i_data_byte >= utf8v_pkg::LEAD2_MIN &&
                             i_data_byte <= utf8v_pkg::LEAD2_MAX) begin
                    dec.partial    = {16'd0, i_data_byte[4:0]};
                    dec.seq_len    = utf8v_pkg::LEN_2;
                    dec.bytes_left = 2'd1;
                end else if (i_data_byte >= utf8v_pkg::LEAD3_MIN &&
                             i_data_byte <= utf8v_pkg::LEAD3_MAX) begin
                    dec.partial    = {17'd0, i_data_byte[3:0]};
                    dec.seq_len    = utf8v_pkg::LEN_3;
                    dec.bytes_left = 2'd2;
                end else if (i_data_byte >= utf8v_pkg::LEAD4_MIN &&
                             i_data_byte <= utf8v_pkg::LEAD4_MAX) begin
                    dec.partial    = {18'd0, i_data_byte[2:0]};
                    dec.seq_len    = utf8v_pkg::LEN_4;
                    dec.bytes_left = 2'd3;
                end else begin
                    err = utf8v_pkg::ERR_BAD_LEAD;
                end
            end else if (i_data_byte[7:6] != 2'b10) begin
                err = utf8v_pkg::ERR_BAD_CONT;
            end else begin
                dec.partial    = {i_dec.partial[14:0], i_data_byte[5:0]};
                dec.bytes_left = i_dec.bytes_left - 2'd1;
                complete       = (dec.bytes_left == 2'd0);
            end

            // Check the finished character, then bump the counts.
            if (complete) begin
                cp        = dec.partial;
                bad_range = (dec.seq_len == utf8v_pkg::LEN_2 && cp < utf8v_pkg::CP_MIN_LEN2) ||
                            (dec.seq_len == utf8v_pkg::LEN_3 && cp < utf8v_pkg::CP_MIN_LEN3) ||
                            (dec.seq_len == utf8v_pkg::LEN_4 && cp < utf8v_pkg::CP_MIN_LEN4) ||
                            (cp > utf8v_pkg::CP_MAX) ||
                            (cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI);
                bad_ctrl  = (cp < utf8v_pkg::CP_CTRL_C0 && cp != utf8v_pkg::CP_LF &&
                             cp != utf8v_pkg::CP_CR && cp != utf8v_pkg::CP_TAB) ||
                            (cp >= utf8v_pkg::CP_DEL && cp <= utf8v_pkg::CP_C1_HI);
                if (bad_range) begin
                    err = utf8v_pkg::ERR_RANGE;
                end else if (bad_ctrl) begin
                    err = utf8v_pkg::ERR_CONTROL;
                end else begin
                    if (cp == utf8v_pkg::CP_LF) begin
                        lines = lines_bump;
                        if (lines_over) begin
                            err = utf8v_pkg::ERR_LINES;
                        end
                    end
                    if (err == utf8v_pkg::ERR_NONE) begin
                        glyphs = glyphs_bump;
                        if (glyphs_over) begin
                            err = utf8v_pkg::ERR_GLYPHS;
                        end
                    end
                    if (err == utf8v_pkg::ERR_NONE) begin
                        glyph  = 1'b1;
                        cp_out = cp;
                    end
                end
                dec.partial = '0;
                dec.seq_len = 3'd0;
            end

            // Flag a sequence cut short by the end of the text.
            if (err == utf8v_pkg::ERR_NONE && i_last_byte && dec.bytes_left != 2'd0) begin
                err = utf8v_pkg::ERR_TRUNCATED;
            end
            dec.first_error = err;
        end
    end

    // Report this byte, then clear per-text state at the end of a text.
    assign o_glyph_count       = glyphs;
    assign o_line_count        = lines;
    assign o_res.text_done     = i_last_byte;
    assign o_res.text_ok       = (dec.first_error == utf8v_pkg::ERR_NONE);
    assign o_res.error_code    = dec.first_error;
    assign o_res.glyph_done    = glyph;
    assign o_res.code_point    = cp_out;
    assign o_dec_next          = i_last_byte ? utf8v_pkg::DEC_CLEAR : dec;
    assign o_glyphs_next       = i_last_byte ? '0 : glyphs;
    assign o_lines_next        = i_last_byte ? COUNT_WIDTH'(1) : lines;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_text_validator_unit.sv =====
// Top level of the UTF-8 text validator: input register, decode step, result register.
// Strict UTF-8 validator that takes one byte per clock and returns one status per byte:
// the first error of the text so far, whether this byte finished a character (and which),
// and the running glyph and line counts checked against the max_glyphs and max_lines
// registers. Throughput is one byte per cycle when neither side stalls; a byte lands in the
// input register at its transfer, and its result is loaded into the result register from
// there once that register is free. The rate is set by the decode step between the input
// register and the result register, which updates the per-text state for each byte.
// Both sides may stall independently; a full result register keeps the input register
// loaded until the result is taken. Write the limit registers only while no text byte is
// in flight.
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_validator_unit #(
    parameter int unsigned COUNT_WIDTH = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [utf8v_pkg::LIMIT_W-1:0] i_cfg_data,
    utf8v_byte_if.sink                         i_byte,
    utf8v_result_if.source                     o_result
);

    logic                          r_s1_valid;
    logic [7:0]                    r_s1_byte;
    logic                          r_s1_last;
    logic [utf8v_pkg::LIMIT_W-1:0] r_max_glyphs;
    logic [utf8v_pkg::LIMIT_W-1:0] r_max_lines;
    utf8v_pkg::t_dec_state         r_dec;
    logic [COUNT_WIDTH-1:0]        r_glyphs;
    logic [COUNT_WIDTH-1:0]        r_lines;
    logic                          r_out_valid;
    utf8v_pkg::t_step_res          r_out_res;
    logic [COUNT_WIDTH-1:0]        r_out_glyphs;
    logic [COUNT_WIDTH-1:0]        r_out_lines;

    utf8v_pkg::t_dec_state         n_dec;
    logic [COUNT_WIDTH-1:0]        n_glyphs;
    logic [COUNT_WIDTH-1:0]        n_lines;
    utf8v_pkg::t_step_res          n_out_res;
    logic [COUNT_WIDTH-1:0]        n_out_glyphs;
    logic [COUNT_WIDTH-1:0]        n_out_lines;

    logic out_free;
    logic s1_adv;
    logic in_ready;

    // Handshake: the result register frees when empty or taken.
    assign out_free = !r_out_valid || o_result.ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign in_ready = !r_s1_valid || out_free;
    assign i_byte.ready = in_ready;

    utf8v_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .i_dec         (r_dec),
        .i_glyphs      (r_glyphs),
        .i_lines       (r_lines),
        .i_data_byte   (r_s1_byte),
        .i_last_byte   (r_s1_last),
        .i_max_glyphs  (r_max_glyphs),
        .i_max_lines   (r_max_lines),
        .o_dec_next    (n_dec),
        .o_glyphs_next (n_glyphs),
        .o_lines_next  (n_lines),
        .o_glyph_count (n_out_glyphs),
        .o_line_count  (n_out_lines),
        .o_res         (n_out_res)
    );

    // Hold configuration, advance input and result stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_glyphs <= utf8v_pkg::MAX_GLYPHS_RST;
            r_max_lines  <= utf8v_pkg::MAX_LINES_RST;
            r_dec        <= utf8v_pkg::DEC_CLEAR;
            r_glyphs     <= '0;
            r_lines      <= COUNT_WIDTH'(1);
        end else begin
            if (i_cfg_we) begin
                case (utf8v_pkg::t_cfg_index'(i_cfg_index))
                    utf8v_pkg::CFG_MAX_GLYPHS: begin
                        r_max_glyphs <= i_cfg_data;
                    end
                    utf8v_pkg::CFG_MAX_LINES: begin
                        r_max_lines <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (in_ready) begin
                r_s1_valid <= i_byte.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_dec    <= n_dec;
                r_glyphs <= n_glyphs;
                r_lines  <= n_lines;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte.valid) begin
            r_s1_byte <= i_byte.data_byte;
            r_s1_last <= i_byte.last_byte;
        end
        if (s1_adv) begin
            r_out_res    <= n_out_res;
            r_out_glyphs <= n_out_glyphs;
            r_out_lines  <= n_out_lines;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.text_done   = r_out_res.text_done;
    assign o_result.text_ok     = r_out_res.text_ok;
    assign o_result.error_code  = r_out_res.error_code;
    assign o_result.glyph_done  = r_out_res.glyph_done;
    assign o_result.code_point  = r_out_res.code_point;
    assign o_result.glyph_count = r_out_glyphs;
    assign o_result.line_count  = r_out_lines;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8v_checker.sv =====
// Port-level assertions for the UTF-8 text validator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module utf8v_checker #(
    parameter int unsigned COUNT_WIDTH = 14
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic                   i_text_done,
    input wire logic                   i_text_ok,
    input wire logic [2:0]             i_error_code,
    input wire logic                   i_glyph_done,
    input wire logic [20:0]            i_code_point,
    input wire logic [COUNT_WIDTH-1:0] i_glyph_count,
    input wire logic [COUNT_WIDTH-1:0] i_line_count
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_text_done) &&
        $stable(i_error_code) && $stable(i_code_point) && $stable(i_glyph_count) &&
        $stable(i_line_count) && $stable(i_glyph_done))
        else $error("result changed while stalled");

    // Verdict flag agrees with the error code.
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_text_ok == (i_error_code == utf8v_pkg::ERR_NONE)))
        else $error("text_ok disagrees with error_code");

    // A finished character only on a clean text and inside the Unicode range.
    a_glyph_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_glyph_done |-> i_text_ok && (i_code_point <= utf8v_pkg::CP_MAX))
        else $error("glyph reported with error or out of range");

    // Drop the code point when no character finished.
    a_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_glyph_done |-> i_code_point == '0)
        else $error("code point without glyph");

    // Line count starts at one and saturates, never wraps.
    a_lines_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_line_count != '0)
        else $error("line count is zero");

endmodule

bind utf8_text_validator_unit utf8v_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_text_done   (o_result.text_done),
    .i_text_ok     (o_result.text_ok),
    .i_error_code  (o_result.error_code),
    .i_glyph_done  (o_result.glyph_done),
    .i_code_point  (o_result.code_point),
    .i_glyph_count (o_result.glyph_count),
    .i_line_count  (o_result.line_count)
);

`default_nettype wire

// ===== tb/utf8_verdict_checker.sv =====
// Checker for the UTF-8 text validator: predicts each per-byte verdict and compares results.
`timescale 1ns / 1ps

module utf8_verdict_checker
    import utf8v_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 14
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [LIMIT_W-1:0] i_cfg_data,
    utf8v_byte_if                   byte_ch,
    utf8v_result_if                 res_ch,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = '1;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                   text_done;
        logic                   text_ok;
        t_err                   error_code;
        logic                   glyph_done;
        logic [CP_W-1:0]        code_point;
        logic [COUNT_WIDTH-1:0] glyph_count;
        logic [COUNT_WIDTH-1:0] line_count;
    } t_verdict;

    // Limits as last written
    logic [LIMIT_W-1:0] lim_glyphs;
    logic [LIMIT_W-1:0] lim_lines;

    // Per-text decoder state
    logic [1:0]             bytes_left;
    logic [2:0]             seq_len;
    logic [CP_W-1:0]        partial;
    logic [COUNT_WIDTH-1:0] glyphs;
    logic [COUNT_WIDTH-1:0] lines;
    t_err                   first_err;

    t_verdict pending_verdicts[$];

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_SAT) ? v : v + 1'b1;
    endfunction

    task automatic clear_text();
        bytes_left = 2'd0;
        seq_len    = 3'd0;
        partial    = '0;
        glyphs     = '0;
        lines      = COUNT_WIDTH'(1);
        first_err  = ERR_NONE;
    endtask

    // Range and control checks on a finished character, then count it
    task automatic finish_glyph(input logic [CP_W-1:0] cp, input logic [2:0] len,
                                output t_err err);
        err = ERR_NONE;
        if ((len == LEN_2 && cp < CP_MIN_LEN2) || (len == LEN_3 && cp < CP_MIN_LEN3) ||
            (len == LEN_4 && cp < CP_MIN_LEN4) || cp > CP_MAX ||
            (cp >= CP_SURR_LO && cp <= CP_SURR_HI)) begin
            err = ERR_RANGE;
        end else if ((cp < CP_CTRL_C0 && cp != CP_LF && cp != CP_CR && cp != CP_TAB) ||
                     (cp >= CP_DEL && cp <= CP_C1_HI)) begin
            err = ERR_CONTROL;
        end else begin
            if (cp == CP_LF) begin
                lines = sat_inc(lines);
                if (lines > lim_lines)
                    err = ERR_LINES;
            end
            if (err == ERR_NONE) begin
                glyphs = sat_inc(glyphs);
                if (glyphs > lim_glyphs)
                    err = ERR_GLYPHS;
            end
        end
    endtask

    // Advance the decoder by one byte and form the verdict it yields
    task automatic predict_verdict(input logic [7:0] b, input logic last, output t_verdict v);
        t_err            err;
        logic            complete;
        logic            glyph;
        logic [CP_W-1:0] cp_out;
        err      = ERR_NONE;
        complete = 1'b0;
        glyph    = 1'b0;
        cp_out   = '0;
        if (first_err == ERR_NONE) begin
            if (bytes_left == 2'd0) begin
                if (b <= 8'h7F) begin
                    partial  = {13'd0, b};
                    seq_len  = LEN_1;
                    complete = 1'b1;
                end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                    partial    = {16'd0, b[4:0]};
                    seq_len    = LEN_2;
                    bytes_left = 2'd1;
                end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                    partial    = {17'd0, b[3:0]};
                    seq_len    = LEN_3;
                    bytes_left = 2'd2;
                end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
                    partial    = {18'd0, b[2:0]};
                    seq_len    = LEN_4;
                    bytes_left = 2'd3;
                end else begin
                    err = ERR_BAD_LEAD;
                end
            end else if (b[7:6] != 2'b10) begin
                err = ERR_BAD_CONT;
            end else begin
                partial    = {partial[CP_W-7:0], b[5:0]};
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == 2'd0)
                    complete = 1'b1;
            end
            if (complete) begin
                finish_glyph(partial, seq_len, err);
                if (err == ERR_NONE) begin
                    glyph  = 1'b1;
                    cp_out = partial;
                end
                partial = '0;
                seq_len = 3'd0;
            end
            if (err == ERR_NONE && last && bytes_left != 2'd0)
                err = ERR_TRUNCATED;
            first_err = err;
        end
        v = '{text_done:   last,
              text_ok:     (first_err == ERR_NONE),
              error_code:  first_err,
              glyph_done:  glyph,
              code_point:  cp_out,
              glyph_count: glyphs,
              line_count:  lines};
        if (last)
            clear_text();
    endtask

    task automatic note_mismatch(input string what, input t_verdict want, input t_verdict got);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("%0t mismatch (%0s): want done=%0b ok=%0b err=%0d glyph=%0b",
                     $realtime, what, want.text_done, want.text_ok, want.error_code,
                     want.glyph_done);
            $display("    want cp=%06h gc=%0d lc=%0d",
                     want.code_point, want.glyph_count, want.line_count);
            $display("    got done=%0b ok=%0b err=%0d glyph=%0b cp=%06h gc=%0d lc=%0d",
                     got.text_done, got.text_ok, got.error_code, got.glyph_done,
                     got.code_point, got.glyph_count, got.line_count);
        end
    endtask

    // Track config writes, check result transfers, predict byte transfers
    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            lim_glyphs = MAX_GLYPHS_RST;
            lim_lines  = MAX_LINES_RST;
            clear_text();
            pending_verdicts.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_MAX_GLYPHS: lim_glyphs = i_cfg_data;
                    CFG_MAX_LINES:  lim_lines  = i_cfg_data;
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                got = '{text_done:   res_ch.text_done,
                        text_ok:     res_ch.text_ok,
                        error_code:  t_err'(res_ch.error_code),
                        glyph_done:  res_ch.glyph_done,
                        code_point:  res_ch.code_point,
                        glyph_count: res_ch.glyph_count,
                        line_count:  res_ch.line_count};
                if (pending_verdicts.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got !== want)
                        note_mismatch("field", want, got);
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                predict_verdict(byte_ch.data_byte, byte_ch.last_byte, want);
                pending_verdicts.push_back(want);
            end
        end
        o_pending = pending_verdicts.size();
    end

endmodule

// ===== tb/utf8_text_validator_unit_test.sv =====
// Testbench top for the UTF-8 text validator: clock, reset, byte stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module utf8_text_validator_unit_test;
    import utf8v_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 100_000;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_BYTES    = 275;
    localparam int NUM_PHASES     = 6;
    localparam int IDLE_PCT       = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [LIMIT_W-1:0] cfg_data;

    int fail_count;
    int pending_count;

    // Both sides run without gaps while set
    bit calm = 1'b0;
    // Receiver holds off for a long stretch once set
    bit hold_req = 1'b0;

    logic [7:0] text_bytes[$];

    utf8v_byte_if                     byte_ch ();
    utf8v_result_if #(.COUNT_WIDTH(14)) res_ch ();

    utf8_text_validator_unit #(
        .COUNT_WIDTH(14)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_byte      (byte_ch),
        .o_result    (res_ch)
    );

    utf8_verdict_checker #(
        .COUNT_WIDTH(14)
    ) u_verdict_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .byte_ch      (byte_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Offer one byte, with random idle cycles first, and hold it until transferred
    task automatic offer_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_text();
        for (int k = 0; k < text_bytes.size(); k++)
            offer_byte(text_bytes[k], k == text_bytes.size() - 1);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_limit(input t_cfg_index idx, input logic [LIMIT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [LIMIT_W-1:0] glyph_lim,
                              input logic [LIMIT_W-1:0] line_lim);
        drain();
        write_limit(CFG_MAX_GLYPHS, glyph_lim);
        write_limit(CFG_MAX_LINES, line_lim);
        cfg_we <= 1'b0;
    endtask

    // Encode a value with a given sequence length (overlong when forced)
    task automatic put_char(input logic [20:0] cp, input int len);
        case (len)
            1: text_bytes.push_back(cp[7:0]);
            2: begin
                text_bytes.push_back({3'b110, cp[10:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                text_bytes.push_back({4'b1110, cp[15:12]});
                text_bytes.push_back({2'b10, cp[11:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                text_bytes.push_back({5'b11110, cp[20:18]});
                text_bytes.push_back({2'b10, cp[17:12]});
                text_bytes.push_back({2'b10, cp[11:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic put_good_char();
        int          pick;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            put_char(21'($urandom_range(8'h20, 8'h7E)), 1);
        end else if (pick < 55) begin
            put_char(CP_LF, 1);
        end else if (pick < 60) begin
            put_char($urandom_range(0, 1) ? CP_TAB : CP_CR, 1);
        end else if (pick < 72) begin
            put_char(21'($urandom_range('hA0, 'h7FF)), 2);
        end else if (pick < 86) begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                cp = cp - 21'h800;
            put_char(cp, 3);
        end else begin
            put_char(21'($urandom_range('h10000, 'h10FFFF)), 4);
        end
    endtask

    task automatic put_bad_char();
        int         len;
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: text_bytes.push_back(8'($urandom_range(0, 255)));
            1: put_char(21'($urandom_range(0, 'h1F)), 1);
            2: begin
                b = 8'($urandom_range('h7F, 'h9F));
                put_char({13'd0, b}, (b == 8'h7F) ? 1 : 2);
            end
            3: begin
                // overlong form
                len = $urandom_range(2, 4);
                if (len == 2)
                    put_char(21'($urandom_range(0, 'h7F)), 2);
                else if (len == 3)
                    put_char(21'($urandom_range(0, 'h7FF)), 3);
                else
                    put_char(21'($urandom_range(0, 'hFFFF)), 4);
            end
            4: put_char(21'($urandom_range('hD800, 'hDFFF)), 3);
            5: put_char(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            6: begin
                // valid lead followed by a non-continuation byte
                text_bytes.push_back(8'($urandom_range(LEAD2_MIN, LEAD4_MAX)));
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                text_bytes.push_back(b);
            end
            default: text_bytes.push_back(8'($urandom_range('h80, 'hBF)));
        endcase
    endtask

    // Mostly well-formed texts, some with one fault, a few pure noise
    task automatic build_text();
        int kind;
        int n;
        int fault_at;
        int len;
        text_bytes.delete();
        kind = $urandom_range(0, 99);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (kind >= 90) begin
            repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            fault_at = (kind < 70) ? -1 : $urandom_range(0, n - 1);
            for (int k = 0; k < n; k++) begin
                if (k == fault_at)
                    put_bad_char();
                else
                    put_good_char();
            end
            // cut the final sequence short now and then
            if ($urandom_range(0, 99) < 10) begin
                len = $urandom_range(2, 4);
                if (len == 2)
                    put_char(21'($urandom_range('h80, 'h7FF)), 2);
                else if (len == 3)
                    put_char(21'($urandom_range('h800, 'hFFFF)), 3);
                else
                    put_char(21'($urandom_range('h10000, 'h10FFFF)), 4);
                repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
            end
        end
    endtask

    // Main stimulus
    initial begin
        int sent;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_MAX_GLYPHS;
        cfg_data          <= '0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed texts with tight limits
        set_limits(13'd3, 13'd2);
        text_bytes = {8'h00};                      // control byte, lowest value
        send_text();
        text_bytes = {8'hFF};                      // bad lead on the final byte
        send_text();
        text_bytes = {8'hC3, 8'hA9, 8'hF4, 8'h8F, 8'hBF, 8'hBF};  // up to U+10FFFF
        send_text();
        text_bytes = {8'h0A, 8'h0A, 8'h41};        // line limit, then bytes after error
        send_text();
        text_bytes = {8'h41, 8'h42, 8'h43, 8'h44}; // glyph limit
        send_text();
        text_bytes = {8'hC3, 8'h41};               // bad continuation on the final byte
        send_text();
        text_bytes = {8'hE2, 8'h82};               // truncated
        send_text();
        text_bytes = {8'hED, 8'hA0, 8'h80};        // surrogate
        send_text();
        text_bytes = {8'hF4, 8'h90, 8'h80, 8'h80}; // above U+10FFFF
        send_text();

        // Zero limits: first LF or first glyph breaks them
        set_limits(13'd0, 13'd0);
        text_bytes = {8'h0A};
        send_text();
        text_bytes = {8'h41};
        send_text();

        // Random phases over several limit settings
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: set_limits(13'd1, 13'd1);
                1: begin
                    set_limits(13'd8191, 13'd8191);
                    calm = 1'b1;
                end
                2: begin
                    set_limits(MAX_GLYPHS_RST, MAX_LINES_RST);
                    hold_req = 1'b1;
                end
                default: set_limits(13'($urandom_range(1, 30)), 13'($urandom_range(1, 6)));
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_text();
                send_text();
                sent += text_bytes.size();
            end
            calm = 1'b0;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/utf8v_pkg.sv
hw/rtl/utf8v_if.sv
hw/rtl/utf8v_step.sv
hw/rtl/utf8_text_validator_unit.sv
hw/rtl/utf8v_checker.sv
tb/utf8_verdict_checker.sv
tb/utf8_text_validator_unit_test.sv
